/* rtl/core/csvfs_pkg.sv */
// Shared constants and types for the CSV field splitter.
`timescale 1ns / 1ps
`default_nettype none

package csvfs_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned EndedW = 2;
	localparam int unsigned OutW   = 16;

	localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
	localparam logic [CharW-1:0] CH_QUOTE = 8'h22;

	// One result, before packing onto the output bus
	typedef struct packed {
		logic              has_char;
		logic [CharW-1:0]  char_out;
		logic [EndedW-1:0] fields_ended;
		logic              line_done;
		logic              unterminated;
	} csvfs_res_t;

endpackage

`default_nettype wire

/* rtl/core/csv_field_splitter.sv */
// Top level of the CSV field splitter: input register, parse logic, result register.
//
// Usage: one byte of a CSV line per request on the s_axis channel; tlast marks
// the final byte of the line. Each accepted byte gives exactly one result on
// m_axis: an optional field character (has_char, char_out), the number of
// fields completed by this byte (0..2), line end on tlast and a flag when the
// line ended inside an open quoted field (the caller should drop that line).
// Quotes open only on an empty field; a doubled quote inside quotes is one
// literal quote, held as pending until the following byte resolves it.
// Each result passes through the input register and then the result register
// before it is offered on m_axis. Throughput: one byte per cycle while the
// receiver takes results, set by the combinational flag update between the
// two registers.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more byte; s_axis_tready falls only when
// both are full. Reset (arst_n low, asynchronous) empties both registers and
// clears the quote and field flags, as at the start of a line; the flags are
// also cleared after every line end.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_splitter
	import csvfs_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [CharW-1:0] s_axis_tdata,  // [7:0] char_in
	input  wire logic            s_axis_tlast,   // last_char
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [OutW-1:0]      m_axis_tdata,   // [0] has_char, [8:1] char_out,
	                                             // [10:9] fields_ended,
	                                             // [11] unterminated, [15:12] zero
	output logic                 m_axis_tlast    // line_done
);

	// input register
	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;

	// result register
	logic       valid_s2;
	csvfs_res_t res_s2;

	// parse state
	logic in_quotes_q;
	logic quote_pending_q;
	logic field_nonempty_q;

	logic       adv;
	csvfs_res_t res_d;
	logic       in_quotes_d;
	logic       quote_pending_d;
	logic       field_nonempty_d;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Flag update for the byte in the input register
	always_comb begin
		logic is_quote;
		logic is_comma;
		logic plain;
		logic [EndedW-1:0] ended;
		is_quote         = (char_s1 == CH_QUOTE);
		is_comma         = (char_s1 == CH_COMMA);
		plain            = 1'b0;
		ended            = '0;
		in_quotes_d      = in_quotes_q;
		quote_pending_d  = 1'b0;
		field_nonempty_d = field_nonempty_q;
		res_d            = '0;

		if (quote_pending_q) begin
			if (is_quote) begin
				// doubled quote: one literal quote, stay quoted
				res_d.has_char   = 1'b1;
				res_d.char_out   = CH_QUOTE;
				field_nonempty_d = 1'b1;
			end else begin
				in_quotes_d = 1'b0;
				plain       = 1'b1;
			end
		end else if (in_quotes_q) begin
			if (is_quote) begin
				if (last_s1)
					in_quotes_d = 1'b0;
				else
					quote_pending_d = 1'b1;
			end else begin
				res_d.has_char   = 1'b1;
				res_d.char_out   = char_s1;
				field_nonempty_d = 1'b1;
			end
		end else begin
			plain = 1'b1;
		end

		if (plain) begin
			if (is_comma) begin
				ended            = 2'd1;
				field_nonempty_d = 1'b0;
			end else if (is_quote && !field_nonempty_q) begin
				in_quotes_d = 1'b1;
			end else begin
				res_d.has_char   = 1'b1;
				res_d.char_out   = char_s1;
				field_nonempty_d = 1'b1;
			end
		end

		if (last_s1) begin
			ended              = ended + 2'd1;
			res_d.unterminated = in_quotes_d;
			in_quotes_d        = 1'b0;
			quote_pending_d    = 1'b0;
			field_nonempty_d   = 1'b0;
		end

		res_d.fields_ended = ended;
		res_d.line_done    = last_s1;
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			in_quotes_q      <= 1'b0;
			quote_pending_q  <= 1'b0;
			field_nonempty_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (m_axis_tready)
				valid_s2 <= 1'b0;
			if (adv) begin
				in_quotes_q      <= in_quotes_d;
				quote_pending_q  <= quote_pending_d;
				field_nonempty_q <= field_nonempty_d;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv)
			res_s2 <= res_d;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = res_s2.line_done;
	assign m_axis_tdata  = {4'b0000, res_s2.unterminated, res_s2.fields_ended,
	                        res_s2.char_out, res_s2.has_char};

`ifndef SYNTHESIS
	// a pending quote only exists inside a quoted section
	a_pend_in_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		quote_pending_q |-> in_quotes_q)
		else $error("quote pending outside quotes");

	// every line end leaves the flags clear for the next line
	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> !in_quotes_q && !quote_pending_q && !field_nonempty_q)
		else $error("state not cleared after line end");

	// unterminated only reported with the line end
	a_unterm_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[11])
		else $error("unterminated flag without line end");

	// at most two fields end on one byte
	a_ended_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:9] != 2'd3)
		else $error("fields_ended out of range");

	// no character reported means the character bits are zero
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'h00)
		else $error("char_out set without has_char");
`endif

endmodule

`default_nettype wire
